/* rtl/spq_pkg.sv */
// shared constants, codes and types of the sorted priority queue
package spq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int TOL_WIDTH   = 31;
  localparam int OP_WIDTH    = 2;
  localparam int STAT_WIDTH  = 2;
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  // difference of two values, one bit more than either side, and room for the tolerance
  localparam int DIFF_W      = ((VALUE_WIDTH + 1 > TOL_WIDTH) ? VALUE_WIDTH + 1 : TOL_WIDTH) + 1;

  // apb register map
  localparam int ADDR_WIDTH  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic REG_TOL   = 1'b0;  // word index of tie_tolerance

  typedef enum logic [OP_WIDTH-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [STAT_WIDTH-1:0] {
    ST_OK        = 2'd0,
    ST_FULL_DROP = 2'd1,
    ST_EMPTY_POP = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_REPORT
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

/* rtl/spq_if.sv */
// request and response channel interfaces of the sorted priority queue
interface spq_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [spq_pkg::OP_WIDTH-1:0]             operation;
  logic signed [spq_pkg::VALUE_WIDTH-1:0]   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface spq_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [spq_pkg::VALUE_WIDTH-1:0]   head_value;
  logic signed [spq_pkg::VALUE_WIDTH-1:0]   tail_value;
  logic [spq_pkg::COUNT_W-1:0]              entry_count;
  logic                                     is_empty;
  logic [spq_pkg::STAT_WIDTH-1:0]           status;

  modport source (output valid, output head_value, output tail_value, output entry_count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input head_value, input tail_value, input entry_count,
                  input is_empty, input status, output ready);
endinterface

/* rtl/spq_cell.sv */
// one queue slot: holds an entry, compares it and shifts with its neighbors
module spq_cell (
  input  logic                                   clk,
  input  spq_pkg::cell_ctl_t                     ctl,
  input  logic signed [spq_pkg::VALUE_WIDTH-1:0] value,
  input  logic [spq_pkg::TOL_WIDTH-1:0]          tol,
  input  logic                                   occupied,
  input  logic                                   at_end,
  input  logic                                   seen_in,
  input  logic signed [spq_pkg::VALUE_WIDTH-1:0] left_entry,
  input  logic signed [spq_pkg::VALUE_WIDTH-1:0] right_entry,
  output logic                                   seen_out,
  output logic signed [spq_pkg::VALUE_WIDTH-1:0] entry
);

  localparam int VW = spq_pkg::VALUE_WIDTH;
  localparam int DW = spq_pkg::DIFF_W;

  logic signed [DW-1:0]  diff;
  logic signed [DW-1:0]  tol_ext;
  logic                  hit;
  logic signed [VW-1:0]  entry_next;

  // exact difference, both sides sign extended
  assign diff    = $signed({{(DW-VW){value[VW-1]}}, value})
                 - $signed({{(DW-VW){entry[VW-1]}}, entry});
  assign tol_ext = $signed({{(DW-spq_pkg::TOL_WIDTH){1'b0}}, tol});

  // insert point: first occupied slot beaten by the new value, else the first free slot
  assign hit      = (occupied && (diff > tol_ext)) || at_end;
  assign seen_out = seen_in || hit;

  always_comb begin
    entry_next = entry;
    if (ctl.push) begin
      if (seen_in) begin
        entry_next = left_entry;
      end else if (hit) begin
        entry_next = value;
      end
    end else if (ctl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* rtl/sorted_priority_queue.sv */
// sorted priority queue top level: cell chain, count, report register and apb port
//
// usage:
//   req channel carries one word per operation: operation (push, pop, clear,
//   no-op) and value (used by push only). rsp channel returns one word per
//   operation with head_value, tail_value, entry_count, is_empty and status,
//   all describing the queue after the operation.
//   the apb port holds tie_tolerance at byte address 0; write it only while
//   the queue has no operation in flight.
// timing:
//   an accepted word updates the cell chain at the accepting edge and moves
//   the control to the report state, which loads the report register and sets
//   rsp.valid; the report word leaves once rsp.ready is high. no word is taken
//   in the report state; the limit is that state, which reads the updated
//   chain for head and tail.
// reset (rst, synchronous):
//   count, tolerance, state and rsp.valid are cleared; cell contents are left
//   as they are and are never read before being written.
// stalls:
//   a word waiting in the report register holds while rsp.ready is low, and
//   req.ready stays low until that word leaves, so nothing is lost or dropped
//   by backpressure. push on full and pop on empty are reported, not stalled.
module sorted_priority_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  spq_req_if.sink                               req,
  spq_rsp_if.source                             rsp,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [spq_pkg::ADDR_WIDTH-1:0]        paddr,
  input  logic [spq_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [spq_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int VW    = spq_pkg::VALUE_WIDTH;
  localparam int CW    = spq_pkg::COUNT_W;
  localparam int IW    = spq_pkg::IDX_W;
  localparam int TW    = spq_pkg::TOL_WIDTH;

  // configuration register
  logic [TW-1:0] tol;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == spq_pkg::REG_TOL);
  assign prdata = (paddr[2] == spq_pkg::REG_TOL)
                ? {{(spq_pkg::APB_DATA_W-TW){1'b0}}, tol} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_wr) begin
      tol <= pwdata[TW-1:0];
    end
  end

  // control state
  spq_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [spq_pkg::STAT_WIDTH-1:0] status, status_next;
  logic             accept;
  logic             report;
  logic             full;
  logic             empty;
  spq_pkg::cell_ctl_t ctl;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  // take a word only in the idle state and when the report register is free or leaving
  assign req.ready = (state == spq_pkg::S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE:   if (accept) state_next = spq_pkg::S_REPORT;
      spq_pkg::S_REPORT: state_next = spq_pkg::S_IDLE;
      default:           state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    report = 1'b0;
    case (state)
      spq_pkg::S_IDLE:   report = 1'b0;
      spq_pkg::S_REPORT: report = 1'b1;
      default:           report = 1'b0;
    endcase
  end

  // decode of the operation into chain command, new count and status
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = status;
    if (accept) begin
      status_next = spq_pkg::ST_OK;
      case (spq_pkg::op_t'(req.operation))
        spq_pkg::OP_PUSH: begin
          if (full) begin
            status_next = spq_pkg::ST_FULL_DROP;
          end else begin
            ctl.push   = 1'b1;
            count_next = count + CW'(1);
          end
        end
        spq_pkg::OP_POP: begin
          if (empty) begin
            status_next = spq_pkg::ST_EMPTY_POP;
          end else begin
            ctl.pop    = 1'b1;
            count_next = count - CW'(1);
          end
        end
        spq_pkg::OP_CLEAR: count_next = '0;
        default:           count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= spq_pkg::S_IDLE;
      count  <= '0;
      status <= spq_pkg::ST_OK;
    end else begin
      state  <= state_next;
      count  <= count_next;
      status <= status_next;
    end
  end

  // chain of cells, slot 0 is the head
  logic signed [VW-1:0] entries [DEPTH];
  logic [DEPTH:0]       seen;

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VW-1:0] left_e;
    logic signed [VW-1:0] right_e;

    if (g == 0) begin : g_first
      assign left_e = req.value;
    end else begin : g_mid_l
      assign left_e = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = entries[g+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .value       (req.value),
      .tol         (tol),
      .occupied    (count > CW'(g)),
      .at_end      (count == CW'(g)),
      .seen_in     (seen[g]),
      .left_entry  (left_e),
      .right_entry (right_e),
      .seen_out    (seen[g+1]),
      .entry       (entries[g])
    );
  end

  // report register
  logic [CW-1:0] last_pos;

  assign last_pos = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (report) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      rsp.head_value  <= empty ? '0 : entries[0];
      rsp.tail_value  <= empty ? '0 : entries[last_pos[IW-1:0]];
      rsp.entry_count <= count;
      rsp.is_empty    <= empty;
      rsp.status      <= status;
    end
  end

endmodule

/* rtl/spq_checker.sv */
// port-level checks on the sorted priority queue, bound to the top level
module spq_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   req_valid,
  input logic                                   req_ready,
  input logic                                   rsp_valid,
  input logic                                   rsp_ready,
  input logic signed [spq_pkg::VALUE_WIDTH-1:0] rsp_head_value,
  input logic [spq_pkg::COUNT_W-1:0]            rsp_entry_count,
  input logic                                   rsp_is_empty,
  input logic [spq_pkg::STAT_WIDTH-1:0]         rsp_status
);

  // a stalled word holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_head_value) && $stable(rsp_status))
    else $error("rsp word changed while stalled");

  // each accepted word is reported: rsp_valid rises through the report state
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 rsp_valid)
    else $error("no report two cycles after accept");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= spq_pkg::COUNT_W'(spq_pkg::DEPTH))
    else $error("entry_count above depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == spq_pkg::ST_EMPTY_POP) |-> rsp_is_empty)
    else $error("empty pop reported on a non-empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_head_value  (rsp.head_value),
  .rsp_entry_count (rsp.entry_count),
  .rsp_is_empty    (rsp.is_empty),
  .rsp_status      (rsp.status)
);

/* dv/spq_order_checker.sv */
// checker for the sorted priority queue: tracks the ordered entries and compares report words
`timescale 1ns / 100ps
module spq_order_checker import spq_pkg::*; #(
  parameter logic [ADDR_WIDTH-1:0] TOL_ADDR = '0
) (
  input  logic                  clk,
  input  logic                  rst,
  spq_req_if                    req,
  spq_rsp_if                    rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] head;
    logic signed [VALUE_WIDTH-1:0] tail;
    logic [COUNT_W-1:0]            count;
    logic                          empty;
    status_t                       status;
  } report_t;

  logic signed [VALUE_WIDTH-1:0] held[$];
  logic [TOL_WIDTH-1:0]          tolerance;
  report_t                       expected_reports[$];
  int                            errors = 0;

  assign mismatches = errors;

  // ordered insert: new value goes ahead of the first entry it beats by more than the tolerance
  function automatic report_t apply_to_queue(op_t op, logic signed [VALUE_WIDTH-1:0] v);
    report_t r;
    int      pos;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held.size() >= DEPTH) begin
          r.status = ST_FULL_DROP;
        end else begin
          pos = held.size();
          for (int i = 0; i < held.size(); i++) begin
            if (longint'(v) - longint'(held[i]) > longint'(tolerance)) begin
              pos = i;
              break;
            end
          end
          held.insert(pos, v);
        end
      end
      OP_POP: begin
        if (held.size() == 0) r.status = ST_EMPTY_POP;
        else void'(held.pop_front());
      end
      OP_CLEAR: held.delete();
      default: ;
    endcase
    r.head  = (held.size() == 0) ? '0 : held[0];
    r.tail  = (held.size() == 0) ? '0 : held[$];
    r.count = COUNT_W'(held.size());
    r.empty = (held.size() == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      held.delete();
      expected_reports.delete();
      tolerance = '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == TOL_ADDR)
        tolerance = pwdata[TOL_WIDTH-1:0];
      if (rsp.valid && rsp.ready) begin
        if (expected_reports.size() == 0) begin
          $error("report word with nothing pending: head_value %0d", rsp.head_value);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("head_value", want.head, rsp.head_value);
          check_field("tail_value", want.tail, rsp.tail_value);
          check_field("entry_count", want.count, rsp.entry_count);
          check_field("is_empty", want.empty, rsp.is_empty);
          check_field("status", want.status, rsp.status);
        end
      end
      if (req.valid && req.ready)
        expected_reports.push_back(apply_to_queue(op_t'(req.operation), req.value));
    end
    outstanding <= expected_reports.size();
  end

endmodule

/* dv/tb_top.sv */
// top of the sorted priority queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
  import spq_pkg::*;

  // tie_tolerance lives at byte address 4 * its word index
  localparam logic [ADDR_WIDTH-1:0] TOL_ADDR = {REG_TOL, 2'b00};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 54;
  // generous: covers the longest receiver stall and sender gap many times over
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  spq_order_checker #(.TOL_ADDR(TOL_ADDR)) chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sender state: burst length, whether valid was left high, and the random value pool
  int                            burst_left = 1;
  bit                            holding = 0;
  bit                            calm = 0;
  logic [TOL_WIDTH-1:0]          cur_tol = '0;
  logic signed [VALUE_WIDTH-1:0] cluster_base = '0;
  int                            seg_left = 0;
  int                            push_pct = 50;

  // apb write: setup cycle, then access cycle; the register takes pwdata at the access edge
  task automatic write_tolerance(input logic [TOL_WIDTH-1:0] tol);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= TOL_ADDR;
    pwdata  <= APB_DATA_W'(tol);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_tol = tol;
  endtask

  // one word on the request channel; valid only drops when a burst ends with a real gap
  task automatic issue(input op_t op, input logic signed [VALUE_WIDTH-1:0] v);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= v;
    do @(posedge clk); while (!req_ch.ready);
    holding = 1;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        holding = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // let every pending report word come back so the queue is idle
  task automatic drain();
    if (holding) begin
      req_ch.valid <= 1'b0;
      holding = 0;
    end
    do @(posedge clk); while (outstanding != 0);
  endtask

  // extremes, full-range noise, and clusters near the tolerance so ties happen often
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    int spread;
    spread = (cur_tol > 64) ? 200 : 3 * int'(cur_tol) + 8;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return cluster_base + $urandom_range(0, spread);
    endcase
  endfunction

  function automatic logic [TOL_WIDTH-1:0] tolerance_for(int phase);
    case (phase)
      0:       return '0;
      1:       return TOL_WIDTH'(1);
      2:       return '1;
      3:       return TOL_WIDTH'($urandom_range(2, 40));
      4:       return TOL_WIDTH'($urandom);
      5:       return TOL_WIDTH'(1000);
      6:       return '0;
      default: return TOL_WIDTH'($urandom_range(0, 3));
    endcase
  endfunction

  // random word: fill, drain and balanced segments keep the count moving
  // between empty and full, with clears and no-ops sprinkled in
  task automatic random_word();
    int roll;
    if (seg_left == 0) begin
      seg_left = $urandom_range(6, 30);
      case ($urandom_range(0, 2))
        0:       push_pct = 70;
        1:       push_pct = 20;
        default: push_pct = 48;
      endcase
    end
    seg_left--;
    roll = $urandom_range(0, 99);
    if (roll < 3)                 issue(OP_CLEAR, $urandom);
    else if (roll < 6)            issue(OP_NOP, $urandom);
    else if (roll < 6 + push_pct) issue(OP_PUSH, pick_value());
    else                          issue(OP_POP, $urandom);
  endtask

  // receiver: ready pattern that switches between random modes
  initial begin
    int         mode;
    int         mode_left;
    logic [7:0] pat;
    mode_left = 0;
    mode = 0;
    pat = '1;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
        pat = 8'($urandom);
      end
      mode_left--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: begin
          rsp_ch.ready <= pat[0];
          pat = {pat[0], pat[7:1]};
        end
        // long stalls: flip only now and then
        default: rsp_ch.ready <= ($urandom_range(0, 15) == 0) ? !rsp_ch.ready : rsp_ch.ready;
      endcase
    end
  end

  // watchdog: end the run if nothing moves on any port for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("sorted_priority_queue test failed");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_NOP;
    req_ch.value     = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_tolerance('0);

    // directed: pop on empty, no-op, extremes with exact ties, then fill to full
    issue(OP_POP, '0);
    issue(OP_NOP, '0);
    issue(OP_PUSH, VAL_MAX);
    issue(OP_PUSH, VAL_MIN);
    issue(OP_PUSH, '0);
    issue(OP_PUSH, '1);
    issue(OP_PUSH, '0);
    issue(OP_PUSH, VAL_MAX);
    issue(OP_POP, '0);
    for (int i = 0; i < 11; i++) issue(OP_PUSH, i * 7 - 30);
    // queue holds 16 now, this one is dropped
    issue(OP_PUSH, 5);
    issue(OP_NOP, '0);
    issue(OP_CLEAR, '0);
    issue(OP_POP, '0);
    drain();

    // random phases, each with its own tolerance; the extremes are among them
    for (int phase = 0; phase < PHASES; phase++) begin
      write_tolerance(tolerance_for(phase));
      calm = (phase == 2 || phase == 5);
      cluster_base = $urandom;
      for (int n = 0; n < PHASE_WORDS; n++) random_word();
      drain();
    end

    // then catch any stray report word before the verdict
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("sorted_priority_queue test passed");
    else $display("sorted_priority_queue test failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/spq_order_checker.sv
dv/tb_top.sv
